// ----- hdl/srf_pkg.sv -----
// shared types and constants for the step reduction factor block
package srf_pkg;

  // fixed field widths
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FACTOR_W      = 29;
  localparam int unsigned COUNT_W       = 16;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned FRAC_BITS_DEF = 28;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROBUST    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b1;

  // outcome of one ratio evaluation
  typedef enum logic [1:0] {
    DIV_BELOW,
    DIV_IN,
    DIV_ABOVE
  } div_cls_e;

  // divider sequencer
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHECK,
    DIV_ITER,
    DIV_DONE
  } div_state_e;

  // top level sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_WAIT_LOW,
    ST_LAST,
    ST_WAIT_MIN,
    ST_HIGH,
    ST_WAIT_HIGH,
    ST_EMIT
  } srf_state_e;

  // divider status toward the sequencer
  typedef struct packed {
    logic     busy;
    logic     done;
    div_cls_e cls;
  } div_status_t;

endpackage

// ----- hdl/srf_div.sv -----
// shared restoring divider that clamps a ratio to the range zero to one
module srf_div #(
  parameter int unsigned FRAC_BITS = srf_pkg::FRAC_BITS_DEF,
  localparam int unsigned DW = (FRAC_BITS + 3 > 34) ? FRAC_BITS + 3 : 34,
  localparam int unsigned QW = FRAC_BITS + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] num_i,
  input  logic signed [DW-1:0] den_i,
  output srf_pkg::div_status_t status_o,
  output logic [QW-1:0]        quot_o
);
  import srf_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAC_BITS);
  localparam logic [CNT_W-1:0] CntLast = CNT_W'(FRAC_BITS - 1);
  localparam logic [QW-1:0] OneQ = {1'b1, {FRAC_BITS{1'b0}}};

  div_state_e state_q, state_d;
  logic signed [DW-1:0] n_q, d_q;
  logic [DW-1:0] r_q;
  logic [FRAC_BITS-1:0] acc_q;
  logic [CNT_W-1:0] cnt_q;
  div_cls_e cls_q;
  logic [QW-1:0] quot_q;

  // one restoring step
  logic [DW:0] r_shift, d_ext, r_sub;
  logic        ge;
  assign r_shift = {r_q, 1'b0};
  assign d_ext   = {1'b0, d_q};
  assign ge      = (r_shift >= d_ext);
  assign r_sub   = ge ? (r_shift - d_ext) : r_shift;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      DIV_IDLE: begin
        if (start_i) state_d = DIV_CHECK;
      end
      DIV_CHECK: begin
        if (d_q == '0 || n_q < 0 || n_q >= d_q) state_d = DIV_DONE;
        else state_d = DIV_ITER;
      end
      DIV_ITER: begin
        if (cnt_q == CntLast) state_d = DIV_DONE;
      end
      DIV_DONE: begin
        state_d = DIV_IDLE;
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath: sign normalize, classify, then one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          n_q <= den_i[DW-1] ? -num_i : num_i;
          d_q <= den_i[DW-1] ? -den_i : den_i;
        end
      end
      DIV_CHECK: begin
        r_q   <= n_q[DW-1:0];
        acc_q <= '0;
        cnt_q <= '0;
        quot_q <= '0;
        if (d_q == '0) begin
          cls_q <= (n_q < 0) ? DIV_BELOW : DIV_ABOVE;
        end else if (n_q < 0) begin
          cls_q <= DIV_BELOW;
        end else if (n_q > d_q) begin
          cls_q <= DIV_ABOVE;
        end else if (n_q == d_q) begin
          cls_q  <= DIV_IN;
          quot_q <= OneQ;
        end else begin
          cls_q <= DIV_IN;
        end
      end
      DIV_ITER: begin
        r_q    <= r_sub[DW-1:0];
        acc_q  <= {acc_q[FRAC_BITS-2:0], ge};
        cnt_q  <= cnt_q + 1'b1;
        quot_q <= {1'b0, acc_q[FRAC_BITS-2:0], ge};
      end
      default: begin
      end
    endcase
  end

  // status toward the sequencer
  always_comb begin
    status_o.busy = (state_q != DIV_IDLE);
    status_o.done = (state_q == DIV_DONE);
    status_o.cls  = cls_q;
    quot_o        = quot_q;
  end

  // checks
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == DIV_IDLE)
    else $error("divider started while busy");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == DIV_ITER |-> ({1'b0, r_q} < d_ext))
    else $error("partial remainder not below divisor");

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == DIV_DONE && cls_q == DIV_IN |-> quot_q <= OneQ)
    else $error("in-range quotient above one");

endmodule

// ----- hdl/step_reduction_factor.sv -----
// step reduction factor: streamed extremes and bound corrections with a shared divider
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------------
//   cfg     | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i / in_stall_o | new_value, old_value, last_element, clear_stats
//   out     | out       | out_valid_o / out_stall_i | factor, corrections, min/max, bound_error
//
// an item with no correction passes the update and last steps; each correction waits
// while the shared restoring divider runs, one quotient bit per cycle. a last item
// adds a high check step and an emit step and may run up to two corrections.
// reset is asynchronous active low; no clearing pass is needed.
// a waiting result sits in the output register; only a last item whose result
// finds that register still full waits in the emit step.
module step_reduction_factor #(
  parameter int unsigned FRAC_BITS = srf_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [srf_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [srf_pkg::DATA_W-1:0]            cfg_data_i,
  // input items
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [srf_pkg::DATA_W-1:0]     new_value_i,
  input  logic signed [srf_pkg::DATA_W-1:0]     old_value_i,
  input  logic                                  last_element_i,
  input  logic                                  clear_stats_i,
  // result items
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [srf_pkg::FACTOR_W-1:0]          factor_o,
  output logic [srf_pkg::COUNT_W-1:0]           low_corrections_o,
  output logic [srf_pkg::COUNT_W-1:0]           high_corrections_o,
  output logic signed [srf_pkg::DATA_W-1:0]     min_seen_o,
  output logic signed [srf_pkg::DATA_W-1:0]     max_seen_o,
  output logic                                  bound_error_o
);
  import srf_pkg::*;

  localparam int unsigned DW   = (FRAC_BITS + 3 > 34) ? FRAC_BITS + 3 : 34;
  localparam int unsigned RF_W = FRAC_BITS + 1;
  localparam logic [RF_W-1:0] OneRf = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [DW-1:0] OneQ = {{(DW - FRAC_BITS - 1){1'b0}}, 1'b1,
                                           {FRAC_BITS{1'b0}}};
  localparam logic signed [DATA_W-1:0] MaxVal = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MinVal = {1'b1, {(DATA_W - 1){1'b0}}};

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return v + {{(COUNT_W - 1){1'b0}}, (v != '1)};
  endfunction

  srf_state_e st_q, st_d;

  // configuration registers
  logic rob_q;
  logic signed [DATA_W-1:0] thr_q;

  // latched item
  logic signed [DATA_W-1:0] n_q, o_q;
  logic last_q, clr_q;

  // vector statistics
  logic [RF_W-1:0] rf_q;
  logic [COUNT_W-1:0] lowc_q, highc_q;
  logic signed [DATA_W-1:0] min_new_q, min_old_q, max_new_q, max_old_q;
  logic err_q, first_q;

  // result register
  logic out_valid_q;
  logic [FACTOR_W-1:0] factor_q;
  logic [COUNT_W-1:0] lowo_q, higho_q;
  logic signed [DATA_W-1:0] mino_q, maxo_q;
  logic erro_q;

  // divider hookup
  logic div_start;
  logic signed [DW-1:0] div_num, div_den;
  div_status_t div_st;
  logic [RF_W-1:0] div_quot;

  srf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .status_o (div_st),
    .quot_o   (div_quot)
  );

  // start-of-vector view of the statistics
  logic signed [DATA_W-1:0] b_min_new, b_min_old, b_max_new, b_max_old;
  logic [COUNT_W-1:0] b_lowc, b_highc;
  logic upd_min, upd_max, robust_hit, min_hit, max_hit;

  always_comb begin
    b_min_new  = first_q ? MaxVal : min_new_q;
    b_min_old  = first_q ? '0 : min_old_q;
    b_max_new  = first_q ? MinVal : max_new_q;
    b_max_old  = first_q ? '0 : max_old_q;
    b_lowc     = (first_q && clr_q) ? '0 : lowc_q;
    b_highc    = (first_q && clr_q) ? '0 : highc_q;
    upd_min    = (n_q < b_min_new);
    upd_max    = (n_q > b_max_new);
    robust_hit = rob_q && (n_q < thr_q);
    min_hit    = !rob_q && (min_new_q < thr_q);
    max_hit    = (DW'(max_new_q) > OneQ);
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) st_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        st_d = robust_hit ? ST_WAIT_LOW : ST_LAST;
      end
      ST_WAIT_LOW: begin
        if (div_st.done) st_d = ST_LAST;
      end
      ST_LAST: begin
        if (!last_q) st_d = ST_IDLE;
        else if (min_hit) st_d = ST_WAIT_MIN;
        else st_d = ST_HIGH;
      end
      ST_WAIT_MIN: begin
        if (div_st.done) st_d = ST_HIGH;
      end
      ST_HIGH: begin
        st_d = max_hit ? ST_WAIT_HIGH : ST_EMIT;
      end
      ST_WAIT_HIGH: begin
        if (div_st.done) st_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) st_d = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // divider requests and operands
  always_comb begin
    div_start = 1'b0;
    div_num   = DW'(o_q);
    div_den   = DW'(o_q) - DW'(n_q);
    case (st_q)
      ST_UPDATE: begin
        div_start = robust_hit;
      end
      ST_LAST: begin
        div_start = last_q && min_hit;
        div_num   = DW'(min_old_q);
        div_den   = DW'(min_old_q) - DW'(min_new_q);
      end
      ST_HIGH: begin
        div_start = max_hit;
        div_num   = OneQ - DW'(max_old_q);
        div_den   = DW'(max_new_q) - DW'(max_old_q);
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o = (st_q != ST_IDLE);

  // factor in output width
  logic [FACTOR_W+RF_W-1:0] rf_wide;
  assign rf_wide = {{FACTOR_W{1'b0}}, rf_q};

  // state, configuration and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      rob_q       <= 1'b1;
      thr_q       <= '0;
      rf_q        <= OneRf;
      lowc_q      <= '0;
      highc_q     <= '0;
      min_new_q   <= MaxVal;
      min_old_q   <= '0;
      max_new_q   <= MinVal;
      max_old_q   <= '0;
      err_q       <= 1'b0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;

      // register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ROBUST:    rob_q <= cfg_data_i[0];
          CFG_THRESHOLD: thr_q <= signed'(cfg_data_i);
          default: begin
          end
        endcase
      end

      // result handshake: load on emit, drop when taken
      if (st_q == ST_EMIT && (!out_valid_q || !out_stall_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      case (st_q)
        ST_UPDATE: begin
          first_q   <= 1'b0;
          if (first_q) begin
            rf_q  <= OneRf;
            err_q <= 1'b0;
          end
          min_new_q <= upd_min ? n_q : b_min_new;
          min_old_q <= upd_min ? o_q : b_min_old;
          max_new_q <= upd_max ? n_q : b_max_new;
          max_old_q <= upd_max ? o_q : b_max_old;
          lowc_q    <= robust_hit ? sat_inc(b_lowc) : b_lowc;
          highc_q   <= b_highc;
        end
        ST_LAST: begin
          if (last_q && min_hit) lowc_q <= sat_inc(lowc_q);
        end
        ST_HIGH: begin
          if (max_hit) highc_q <= sat_inc(highc_q);
        end
        ST_WAIT_LOW, ST_WAIT_MIN, ST_WAIT_HIGH: begin
          // apply the clamped ratio; only the robust low check flags errors
          if (div_st.done) begin
            case (div_st.cls)
              DIV_BELOW: begin
                rf_q <= '0;
                if (st_q == ST_WAIT_LOW) err_q <= 1'b1;
              end
              DIV_ABOVE: begin
                if (st_q == ST_WAIT_LOW) err_q <= 1'b1;
              end
              DIV_IN: begin
                if (div_quot < rf_q) rf_q <= div_quot;
              end
              default: begin
              end
            endcase
          end
        end
        ST_EMIT: begin
          if (!out_valid_q || !out_stall_i) first_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // item capture and result payload
  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && in_valid_i) begin
      n_q    <= new_value_i;
      o_q    <= old_value_i;
      last_q <= last_element_i;
      clr_q  <= clear_stats_i;
    end
    if (st_q == ST_EMIT && (!out_valid_q || !out_stall_i)) begin
      factor_q <= rf_wide[FACTOR_W-1:0];
      lowo_q   <= lowc_q;
      higho_q  <= highc_q;
      mino_q   <= min_new_q;
      maxo_q   <= max_new_q;
      erro_q   <= err_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign factor_o           = factor_q;
  assign low_corrections_o  = lowo_q;
  assign high_corrections_o = higho_q;
  assign min_seen_o         = mino_q;
  assign max_seen_o         = maxo_q;
  assign bound_error_o      = erro_q;

  // checks
  a_factor_le_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_q <= OneRf)
    else $error("running factor above one");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_st.busy)
    else $error("divider request while divider busy");

  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q == ST_EMIT))
    else $error("result raised outside emit step");

  a_err_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(err_q) |-> $past(st_q == ST_WAIT_LOW))
    else $error("bound error raised outside robust low check");

endmodule
